// ----- hdl/tdc_pkg.sv -----
`timescale 1ns / 1ps

package tdc_pkg;

  // Item functions
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_PIXEL = 2'd2;
  localparam logic [1:0] FUNC_GLYPH = 2'd3;

  // D5 page decode
  localparam logic [15:0] ADDR_BANK  = 16'hD508;
  localparam logic [15:0] ADDR_SEL   = 16'hD580;
  localparam logic [15:0] ADDR_DATA  = 16'hD581;
  localparam logic [15:0] ADDR_SCR_A = 16'hD583;
  localparam logic [15:0] ADDR_SCR_B = 16'hD585;

  // Register file
  localparam int REG_COUNT = 64;
  localparam int REG_AW    = 6;

  localparam logic [REG_AW-1:0] REG_SEL       = 6'h00;
  localparam logic [REG_AW-1:0] REG_CUR_TOP   = 6'h0A;
  localparam logic [REG_AW-1:0] REG_CUR_BOT   = 6'h0B;
  localparam logic [REG_AW-1:0] REG_START_HI  = 6'h0C;
  localparam logic [REG_AW-1:0] REG_START_LO  = 6'h0D;
  localparam logic [REG_AW-1:0] REG_CUR_HI    = 6'h0E;
  localparam logic [REG_AW-1:0] REG_CUR_LO    = 6'h0F;
  localparam logic [REG_AW-1:0] REG_UPD_HI    = 6'h12;
  localparam logic [REG_AW-1:0] REG_UPD_LO    = 6'h13;

  // Cursor mode field (bits 6:5 of the cursor top register): this code hides it
  localparam logic [1:0] CUR_MODE_OFF = 2'b01;

  localparam logic [7:0] READ_UNMAPPED = 8'hFF;

  // Glyph store
  localparam int GLYPH_DEPTH = 4096;
  localparam int GLYPH_AW    = 12;

  // Display position width
  localparam int POS_W = 14;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic div;
    logic rem;
    logic pos;
    logic mod1;
    logic mod2;
    logic scr_rd;
    logic scr_wr;
    logic carry;
    logic glyph_rd;
    logic glyph_wr;
    logic reg_rd;
    logic reg_wr;
    logic sel_wr;
    logic bank_wr;
    logic finish;
  } tdc_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       is_bank;
    logic       is_sel;
    logic       is_data;
    logic       is_scr;
    logic       row_ok;
    logic       clr_last;
  } tdc_stat_t;

endpackage

// ----- hdl/text_display_crtc_card.sv -----
`timescale 1ns / 1ps

// Eighty-column text card: CRTC-style register file, screen RAM and glyph
// store behind one command port. An item is taken when start_i is high and
// busy_o low; its single result appears on the result ports for exactly one
// cycle with done_o high, and the receiver cannot stall it, so sample it then.
// busy_o drops in the same cycle done_o rises, so the next item can be issued
// straight away. Items run one at a time through a sequencer; after decode
// each takes these steps, then a finish step that registers the result:
//   bus write to bank latch, register select or register data, or to an
//   ignored address, glyph load: a write step
//   register read: a register file read; unmapped read: none
//   screen RAM read or write: two-step modulo of the update address, then
//   the screen RAM access; pixel fetch: row/line split, position sum,
//   modulo, screen RAM read and glyph read in that order; it ends after
//   the position sum when the scan line lies below the text area.
// After reset the screen RAM is swept to zero, one entry a cycle, and busy_o
// stays high until the sweep ends. The glyph store is not cleared and
// reads of never-loaded entries are undefined.
// rom_bank_o and eighty_column_o show the latch contents at all times and
// hold their post-item value when done_o is high.

module text_display_crtc_card #(
  parameter int SCREEN_DEPTH = 2048,
  parameter int TEXT_ROWS    = 24,
  parameter int CELL_LINES   = 10,
  parameter int TEXT_COLUMNS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] bus_address_i,
  input  logic [7:0]  write_byte_i,
  input  logic [11:0] glyph_address_i,
  input  logic [8:0]  scan_line_i,
  input  logic [6:0]  char_column_i,
  input  logic        blink_phase_i,
  output logic [7:0]  read_data_o,
  output logic [7:0]  pixel_bits_o,
  output logic        foreground_entry_o,
  output logic [3:0]  rom_bank_o,
  output logic        eighty_column_o
);
  import tdc_pkg::*;

  tdc_cmd_t  cmd;   // sequencer -> datapath strobes
  tdc_stat_t stat;  // decoded item and datapath flags

  // Sequencer: clearing sweep, decode, then one state per datapath step.
  tdc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Datapath: item latch, register file, divider by cell height, modulo
  // unit, screen RAM, glyph store and result registers.
  tdc_datapath #(
    .SCREEN_DEPTH (SCREEN_DEPTH),
    .TEXT_ROWS    (TEXT_ROWS),
    .CELL_LINES   (CELL_LINES),
    .TEXT_COLUMNS (TEXT_COLUMNS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (func_i),
    .bus_address_i   (bus_address_i),
    .write_byte_i    (write_byte_i),
    .glyph_address_i (glyph_address_i),
    .scan_line_i     (scan_line_i),
    .char_column_i   (char_column_i),
    .blink_phase_i   (blink_phase_i),
    .read_data_o     (read_data_o),
    .pixel_bits_o    (pixel_bits_o),
    .rom_bank_o      (rom_bank_o),
    .eighty_column_o (eighty_column_o)
  );

  // palette entry for foreground pixels is fixed
  assign foreground_entry_o = 1'b1;

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o not raised after an item was taken");

  // No result can appear the cycle right after an item was taken.
  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !done_o)
    else $error("result strobe too early after an item was taken");

  // A result is shown only once the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

  // The clearing sweep never overlaps a write from an item.
  a_clear_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !(cmd.scr_wr || cmd.load))
    else $error("screen clear overlaps item work");

endmodule

// ----- hdl/tdc_ctrl.sv -----
`timescale 1ns / 1ps

module tdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tdc_pkg::tdc_stat_t stat_i,
  output tdc_pkg::tdc_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              done_o
);
  import tdc_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DEC   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_REM   = 4'd4;
  localparam logic [3:0] ST_POS   = 4'd5;
  localparam logic [3:0] ST_MOD1  = 4'd6;
  localparam logic [3:0] ST_MOD2  = 4'd7;
  localparam logic [3:0] ST_SRD   = 4'd8;
  localparam logic [3:0] ST_GRD   = 4'd9;
  localparam logic [3:0] ST_SWR   = 4'd10;
  localparam logic [3:0] ST_RRD   = 4'd11;
  localparam logic [3:0] ST_WR    = 4'd12;
  localparam logic [3:0] ST_GWR   = 4'd13;
  localparam logic [3:0] ST_FIN   = 4'd14;

  logic [3:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DEC;
        end
      end
      ST_DEC: begin
        case (stat_i.func)
          FUNC_READ: begin
            if (stat_i.is_data) begin
              state_d = ST_RRD;
            end else if (stat_i.is_scr) begin
              state_d = ST_MOD1;
            end else begin
              state_d = ST_FIN;
            end
          end
          FUNC_WRITE: begin
            state_d = stat_i.is_scr ? ST_MOD1 : ST_WR;
          end
          FUNC_PIXEL: state_d = ST_DIV;
          default:    state_d = ST_GWR;
        endcase
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_REM;
      end
      ST_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = ST_POS;
      end
      ST_POS: begin
        cmd_o.pos = 1'b1;
        state_d   = stat_i.row_ok ? ST_MOD1 : ST_FIN;
      end
      ST_MOD1: begin
        cmd_o.mod1 = 1'b1;
        state_d    = ST_MOD2;
      end
      ST_MOD2: begin
        cmd_o.mod2 = 1'b1;
        state_d    = (stat_i.func == FUNC_WRITE) ? ST_SWR : ST_SRD;
      end
      ST_SRD: begin
        cmd_o.scr_rd = 1'b1;
        cmd_o.carry  = (stat_i.func == FUNC_READ);
        state_d      = (stat_i.func == FUNC_PIXEL) ? ST_GRD : ST_FIN;
      end
      ST_GRD: begin
        cmd_o.glyph_rd = 1'b1;
        state_d        = ST_FIN;
      end
      ST_SWR: begin
        cmd_o.scr_wr = 1'b1;
        state_d      = ST_FIN;
      end
      ST_RRD: begin
        cmd_o.reg_rd = 1'b1;
        state_d      = ST_FIN;
      end
      ST_WR: begin
        cmd_o.bank_wr = stat_i.is_bank;
        cmd_o.sel_wr  = stat_i.is_sel;
        cmd_o.reg_wr  = stat_i.is_data;
        state_d       = ST_FIN;
      end
      ST_GWR: begin
        cmd_o.glyph_wr = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

// ----- hdl/tdc_datapath.sv -----
`timescale 1ns / 1ps

module tdc_datapath #(
  parameter int SCREEN_DEPTH = 2048,
  parameter int TEXT_ROWS    = 24,
  parameter int CELL_LINES   = 10,
  parameter int TEXT_COLUMNS = 80
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdc_pkg::tdc_cmd_t  cmd_i,
  output tdc_pkg::tdc_stat_t stat_o,
  input  logic [1:0]         func_i,
  input  logic [15:0]        bus_address_i,
  input  logic [7:0]         write_byte_i,
  input  logic [11:0]        glyph_address_i,
  input  logic [8:0]         scan_line_i,
  input  logic [6:0]         char_column_i,
  input  logic               blink_phase_i,
  output logic [7:0]         read_data_o,
  output logic [7:0]         pixel_bits_o,
  output logic [3:0]         rom_bank_o,
  output logic               eighty_column_o
);
  import tdc_pkg::*;

  localparam int AW = $clog2(SCREEN_DEPTH);
  // reciprocals: estimate is never above the true quotient and at most one below
  localparam logic [16:0] RECIP_L = 17'((1 << 16) / CELL_LINES);
  localparam logic [20:0] RECIP_D = 21'((1 << 28) / SCREEN_DEPTH);

  // latched item
  logic [1:0]  func_q;
  logic [15:0] addr_q;
  logic [7:0]  wbyte_q;
  logic [11:0] gaddr_q;
  logic [8:0]  scan_q;
  logic [6:0]  col_q;
  logic        blink_q;

  // register file: shadows for fixed-use entries, memory for the rest
  logic [7:0]  reg0_q, r0a_q, r0b_q, r0c_q, r0d_q, r0e_q, r0f_q, r12_q, r13_q;
  logic [7:0]  reg_mem [REG_COUNT];
  logic [REG_COUNT-1:0] reg_vld_q;
  logic [7:0]  reg_rd_q;
  logic        reg_vld_rd_q;
  logic [REG_AW-1:0] idx;

  // pixel path
  logic [8:0]  qest_q, row_q;
  logic [3:0]  line_q;
  logic [POS_W-1:0] pos_q;
  logic [25:0] div_prod;
  logic [13:0] qprod;
  logic [8:0]  rem_w;
  logic [17:0] pos_sum;
  logic        row_ok;

  // modulo unit
  logic [POS_W-1:0] mod_x;
  logic [34:0] mod_prod;
  logic [6:0]  qd_q;
  logic [20:0] qd_prod;
  logic [14:0] md_rem;
  logic [AW-1:0] scr_addr_q;

  // memories
  logic [7:0]  scr_mem [SCREEN_DEPTH];
  logic [7:0]  scr_rd_q;
  logic [AW-1:0] clr_q;
  logic        scr_we;
  logic [AW-1:0] scr_waddr;
  logic [7:0]  scr_wdata;
  logic [7:0]  glyph_mem [GLYPH_DEPTH];
  logic [7:0]  glyph_rd_q;

  // results
  logic [7:0]  rd_q, px_q, rd_d, px_d, reg_val, bits;
  logic [3:0]  bank_q;
  logic        vid_q;
  logic        cursor;
  logic        is_scr;

  assign idx    = reg0_q[REG_AW-1:0];
  assign is_scr = (addr_q == ADDR_SCR_A) || (addr_q == ADDR_SCR_B);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      addr_q  <= bus_address_i;
      wbyte_q <= write_byte_i;
      gaddr_q <= glyph_address_i;
      scan_q  <= scan_line_i;
      col_q   <= char_column_i;
      blink_q <= blink_phase_i;
    end
  end

  // scan line -> text row and cell line
  assign div_prod = 26'(scan_q) * 26'(RECIP_L);
  assign qprod    = 14'(qest_q) * 14'(CELL_LINES);
  assign rem_w    = scan_q - qprod[8:0];
  assign row_ok   = (row_q < 9'(TEXT_ROWS));
  assign pos_sum  = 18'(row_q) * 18'(TEXT_COLUMNS) + 18'(col_q)
                  + 18'({r0c_q[5:0], r0d_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div) begin
      qest_q <= div_prod[16 +: 9];
    end
    if (cmd_i.rem) begin
      if (rem_w >= 9'(CELL_LINES)) begin
        row_q  <= qest_q + 9'd1;
        line_q <= 4'(rem_w - 9'(CELL_LINES));
      end else begin
        row_q  <= qest_q;
        line_q <= rem_w[3:0];
      end
    end
    if (cmd_i.pos) begin
      pos_q <= pos_sum[POS_W-1:0];
    end
  end

  // shared reduction modulo screen depth
  assign mod_x    = (func_q == FUNC_PIXEL) ? pos_q : {r12_q[5:0], r13_q};
  assign mod_prod = 35'(mod_x) * 35'(RECIP_D);
  assign qd_prod  = 21'(qd_q) * 21'(SCREEN_DEPTH);
  assign md_rem   = 15'(mod_x) - qd_prod[14:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod1) begin
      qd_q <= mod_prod[28 +: 7];
    end
    if (cmd_i.mod2) begin
      if (md_rem >= 15'(SCREEN_DEPTH)) begin
        scr_addr_q <= AW'(md_rem - 15'(SCREEN_DEPTH));
      end else begin
        scr_addr_q <= AW'(md_rem);
      end
    end
  end

  // screen RAM, cleared by a sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign scr_we    = cmd_i.clr_wr || cmd_i.scr_wr;
  assign scr_waddr = cmd_i.clr_wr ? clr_q : scr_addr_q;
  assign scr_wdata = cmd_i.clr_wr ? 8'h00 : wbyte_q;

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    if (cmd_i.scr_rd) begin
      scr_rd_q <= scr_mem[scr_addr_q];
    end
  end

  // glyph store
  always_ff @(posedge clk_i) begin
    if (cmd_i.glyph_wr) begin
      glyph_mem[gaddr_q] <= wbyte_q;
    end
    if (cmd_i.glyph_rd) begin
      glyph_rd_q <= glyph_mem[{1'b0, scr_rd_q[6:0], line_q}];
    end
  end

  // register memory and its valid bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.reg_wr) begin
      reg_mem[idx] <= wbyte_q;
    end
    if (cmd_i.reg_rd) begin
      reg_rd_q     <= reg_mem[idx];
      reg_vld_rd_q <= reg_vld_q[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_vld_q <= '0;
    end else if (cmd_i.reg_wr) begin
      reg_vld_q[idx] <= 1'b1;
    end
  end

  // shadow registers, bank and video latch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg0_q <= '0;
      r0a_q  <= '0;
      r0b_q  <= '0;
      r0c_q  <= '0;
      r0d_q  <= '0;
      r0e_q  <= '0;
      r0f_q  <= '0;
      r12_q  <= '0;
      r13_q  <= '0;
      bank_q <= '0;
      vid_q  <= 1'b0;
    end else begin
      if (cmd_i.bank_wr) begin
        bank_q <= {wbyte_q[5], wbyte_q[2:0]};
        vid_q  <= wbyte_q[4];
      end
      if (cmd_i.sel_wr) begin
        reg0_q <= wbyte_q;
      end
      if (cmd_i.reg_wr) begin
        case (idx)
          REG_SEL:      reg0_q <= wbyte_q;
          REG_CUR_TOP:  r0a_q  <= wbyte_q;
          REG_CUR_BOT:  r0b_q  <= wbyte_q;
          REG_START_HI: r0c_q  <= wbyte_q;
          REG_START_LO: r0d_q  <= wbyte_q;
          REG_CUR_HI:   r0e_q  <= wbyte_q;
          REG_CUR_LO:   r0f_q  <= wbyte_q;
          REG_UPD_HI:   r12_q  <= wbyte_q;
          REG_UPD_LO:   r13_q  <= wbyte_q;
          default: ;
        endcase
      end
      // update address steps after a screen write; low byte wrap carries
      if (cmd_i.scr_wr) begin
        r13_q <= r13_q + 8'd1;
        if (r13_q == 8'hFF) begin
          r12_q <= {2'b00, r12_q[5:0] + 6'd1};
        end
      end
      // a screen read only carries, when the low byte is zero
      if (cmd_i.carry && (r13_q == 8'h00)) begin
        r12_q <= {2'b00, r12_q[5:0] + 6'd1};
      end
    end
  end

  // result assembly
  always_comb begin
    case (idx)
      REG_SEL:      reg_val = reg0_q;
      REG_CUR_TOP:  reg_val = r0a_q;
      REG_CUR_BOT:  reg_val = r0b_q;
      REG_START_HI: reg_val = r0c_q;
      REG_START_LO: reg_val = r0d_q;
      REG_CUR_HI:   reg_val = r0e_q;
      REG_CUR_LO:   reg_val = r0f_q;
      REG_UPD_HI:   reg_val = r12_q;
      REG_UPD_LO:   reg_val = r13_q;
      default:      reg_val = reg_vld_rd_q ? reg_rd_q : 8'h00;
    endcase
  end

  assign cursor = (pos_q == {r0e_q[5:0], r0f_q}) && !blink_q
               && ({1'b0, line_q} >= r0a_q[4:0])
               && ({1'b0, line_q} <= r0b_q[4:0])
               && (r0a_q[6:5] != CUR_MODE_OFF);
  assign bits   = glyph_rd_q ^ {8{scr_rd_q[7]}} ^ {8{cursor}};

  always_comb begin
    rd_d = 8'h00;
    px_d = 8'h00;
    case (func_q)
      FUNC_READ: begin
        if (addr_q == ADDR_DATA) begin
          rd_d = reg_val;
        end else if (is_scr) begin
          rd_d = scr_rd_q;
        end else begin
          rd_d = READ_UNMAPPED;
        end
      end
      FUNC_PIXEL: begin
        px_d = row_ok ? bits : 8'h00;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rd_q <= rd_d;
      px_q <= px_d;
    end
  end

  assign stat_o.func     = func_q;
  assign stat_o.is_bank  = (addr_q == ADDR_BANK);
  assign stat_o.is_sel   = (addr_q == ADDR_SEL);
  assign stat_o.is_data  = (addr_q == ADDR_DATA);
  assign stat_o.is_scr   = is_scr;
  assign stat_o.row_ok   = row_ok;
  assign stat_o.clr_last = (clr_q == AW'(SCREEN_DEPTH - 1));

  assign read_data_o     = rd_q;
  assign pixel_bits_o    = px_q;
  assign rom_bank_o      = bank_q;
  assign eighty_column_o = vid_q;

endmodule
